>>> sv/fem_pkg.sv
// ----------------------------------------------------------------------------
// fem_pkg
// Shared types and constants of the flow export message builder.
// ----------------------------------------------------------------------------
`default_nettype none

package fem_pkg;

    localparam int ADDRESS_BITS_DEF = 16;
    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
    localparam int BODY_BYTES = 20;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] MODE_BEGIN = 3'd0;
    localparam logic [2:0] MODE_TMPL_HDR = 3'd1;
    localparam logic [2:0] MODE_TMPL_FIELD = 3'd2;
    localparam logic [2:0] MODE_SET_BEGIN = 3'd3;
    localparam logic [2:0] MODE_DATA_BYTE = 3'd4;
    localparam logic [2:0] MODE_SET_END = 3'd5;
    localparam logic [2:0] MODE_FINISH = 3'd6;

    localparam logic [15:0] VERSION_V9 = 16'd9;
    localparam logic [15:0] VERSION_IPFIX = 16'd10;
    localparam logic [15:0] TMPL_SET_ID_V9 = 16'd0;
    localparam logic [15:0] TMPL_SET_ID_IPFIX = 16'd2;
    localparam logic [15:0] MIN_DATA_SET_ID = 16'd256;
    localparam logic [15:0] COUNT_OFFSET = 16'd2;

    // running header length after each header word
    localparam logic [4:0] HDR_BOUND [6] = '{5'd2, 5'd4, 5'd8, 5'd12, 5'd16, 5'd20};

    // write plan of one item: pad run, set-length patch, body run, final patch
    typedef struct packed {
        logic [15:0]  pad_addr;
        logic [1:0]   pad_n;
        logic         pa_en;
        logic [15:0]  pa_addr;
        logic [15:0]  pa_val;
        logic [15:0]  body_addr;
        logic [4:0]   body_n;
        logic [159:0] body;
        logic         pb_en;
        logic [15:0]  pb_addr;
        logic [15:0]  pb_val;
        logic         ok;
        logic [15:0]  mlen;
    } t_desc;

endpackage

`default_nettype wire

>>> sv/fem_front.sv
// ----------------------------------------------------------------------------
// fem_front
// Decodes command items, keeps the builder state, emits one write plan each.
// ----------------------------------------------------------------------------
`default_nettype none

module fem_front #(
    parameter int ADDRESS_BITS = fem_pkg::ADDRESS_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [15:0]   i_cap,
    input  wire logic          i_take,
    input  wire logic [2:0]    i_mode,
    input  wire logic          i_use_ipfix,
    input  wire logic [31:0]   i_header_word_0,
    input  wire logic [31:0]   i_header_word_1,
    input  wire logic [31:0]   i_header_word_2,
    input  wire logic [31:0]   i_header_word_3,
    input  wire logic [15:0]   i_id_or_type,
    input  wire logic [15:0]   i_count_or_length,
    input  wire logic [7:0]    i_data_value,
    input  wire logic          i_record_first,
    input  wire logic          i_record_last,
    output fem_pkg::t_desc     o_desc
);

    localparam int AB = ADDRESS_BITS;
    localparam logic [16:0] ADDR_LIM = 17'((17'd1 << AB) - 17'd1);

    logic [AB-1:0] r_wp, n_wp;
    logic [AB-1:0] r_dss, n_dss;
    logic [AB-1:0] r_tss, n_tss;
    logic          r_open, n_open;
    logic [15:0]   r_tfl, n_tfl;
    logic [15:0]   r_rt, n_rt;
    logic          r_ipf, n_ipf;
    logic          r_err, n_err;

    logic [16:0]   capx;
    logic [AB-1:0] diff;
    logic [1:0]    pad_len;
    logic          cl_fail;
    logic          cl_err;
    logic [AB-1:0] cl_wp;
    logic          do_close;
    logic [AB-1:0] base_wp;
    logic          base_err;
    logic [2:0]    nfit;
    logic [2:0]    k;
    logic [2:0]    kb;
    logic [2:0]    nw;
    logic [4:0]    bn;
    logic          e;

    assign capx = ({1'b0, i_cap} < ADDR_LIM) ? {1'b0, i_cap} : ADDR_LIM;

    // closing an open data set: v9 pad to 4 octets, then patch set length
    always_comb begin
        diff = r_wp - r_dss;
        pad_len = r_ipf ? 2'd0 : 2'(2'd0 - diff[1:0]);
        cl_fail = !r_ipf && (17'(r_wp) + 17'(pad_len) > capx);
        cl_err = r_err || cl_fail;
        cl_wp = cl_err ? r_wp : r_wp + AB'(pad_len);
    end

    always_comb begin
        unique case (i_mode)
            fem_pkg::MODE_TMPL_HDR:   do_close = r_open && (i_count_or_length != 16'd0);
            fem_pkg::MODE_SET_BEGIN:  do_close = r_open
                                        && (i_id_or_type >= fem_pkg::MIN_DATA_SET_ID);
            fem_pkg::MODE_SET_END:    do_close = r_open;
            fem_pkg::MODE_FINISH:     do_close = r_open;
            default:                  do_close = 1'b0;
        endcase
        base_wp = do_close ? cl_wp : r_wp;
        base_err = do_close ? cl_err : r_err;
    end

    // how many two-octet puts fit from base_wp (monotone)
    always_comb begin
        nfit = 3'd0;
        for (int i = 1; i <= 4; i++) begin
            if (17'(base_wp) + 17'(2 * i) <= capx) begin
                nfit = 3'(i);
            end
        end
    end

    always_comb begin
        n_wp = r_wp;
        n_dss = r_dss;
        n_tss = r_tss;
        n_open = r_open;
        n_tfl = r_tfl;
        n_rt = r_rt;
        n_ipf = r_ipf;
        n_err = r_err;
        o_desc = '0;
        k = 3'd0;
        kb = 3'd0;
        nw = 3'd0;
        bn = 5'd0;
        e = 1'b0;

        if (do_close) begin
            o_desc.pad_addr = 16'(r_wp);
            o_desc.pad_n = cl_err ? 2'd0 : pad_len;
            o_desc.pa_en = !cl_err;
            o_desc.pa_addr = 16'(r_dss) + 16'd2;
            o_desc.pa_val = 16'(cl_wp - r_dss);
            n_open = 1'b0;
            n_err = cl_err;
            n_wp = cl_wp;
        end

        unique case (i_mode)
            fem_pkg::MODE_BEGIN: begin
                n_dss = '0;
                n_tss = '0;
                n_open = 1'b0;
                n_tfl = '0;
                n_rt = '0;
                n_ipf = i_use_ipfix;
                nw = i_use_ipfix ? 3'd5 : 3'd6;
                for (int i = 0; i < 6; i++) begin
                    if (3'(i) < nw && 17'(fem_pkg::HDR_BOUND[i]) <= capx) begin
                        kb = 3'(i + 1);
                        bn = fem_pkg::HDR_BOUND[i];
                    end
                end
                o_desc.body = {i_use_ipfix ? fem_pkg::VERSION_IPFIX : fem_pkg::VERSION_V9,
                               16'd0, i_header_word_0, i_header_word_1,
                               i_header_word_2, i_header_word_3};
                o_desc.body_addr = '0;
                o_desc.body_n = bn;
                n_wp = AB'(bn);
                n_err = kb < nw;
                o_desc.ok = !(kb < nw);
            end
            fem_pkg::MODE_TMPL_HDR: begin
                if (i_count_or_length != 16'd0) begin
                    k = base_err ? 3'd0 : nfit;
                    n_tss = base_wp;
                    o_desc.body = {r_ipf ? fem_pkg::TMPL_SET_ID_IPFIX : fem_pkg::TMPL_SET_ID_V9,
                                   16'd0, i_id_or_type, i_count_or_length, 96'd0};
                    o_desc.body_addr = 16'(base_wp);
                    o_desc.body_n = {k, 1'b0};
                    n_wp = base_wp + AB'({k, 1'b0});
                    n_err = base_err || (k < 3'd4);
                    n_tfl = i_count_or_length;
                    n_rt = r_rt + 16'd1;
                    o_desc.ok = !(base_err || (k < 3'd4));
                end
            end
            fem_pkg::MODE_TMPL_FIELD: begin
                if (r_tfl != 16'd0) begin
                    k = base_err ? 3'd0 : ((nfit > 3'd2) ? 3'd2 : nfit);
                    e = base_err || (k < 3'd2);
                    o_desc.body = {i_id_or_type, i_count_or_length, 128'd0};
                    o_desc.body_addr = 16'(base_wp);
                    o_desc.body_n = {k, 1'b0};
                    n_wp = base_wp + AB'({k, 1'b0});
                    n_err = e;
                    n_tfl = r_tfl - 16'd1;
                    if (r_tfl == 16'd1 && !e) begin
                        o_desc.pb_en = 1'b1;
                        o_desc.pb_addr = 16'(r_tss) + 16'd2;
                        o_desc.pb_val = 16'(base_wp + AB'({k, 1'b0}) - r_tss);
                    end
                    o_desc.ok = !e;
                end
            end
            fem_pkg::MODE_SET_BEGIN: begin
                if (i_id_or_type >= fem_pkg::MIN_DATA_SET_ID) begin
                    k = base_err ? 3'd0 : ((nfit > 3'd2) ? 3'd2 : nfit);
                    e = base_err || (k < 3'd2);
                    n_dss = base_wp;
                    n_open = 1'b1;
                    o_desc.body = {i_id_or_type, 16'd0, 128'd0};
                    o_desc.body_addr = 16'(base_wp);
                    o_desc.body_n = {k, 1'b0};
                    n_wp = base_wp + AB'({k, 1'b0});
                    n_err = e;
                    o_desc.ok = !e;
                end
            end
            fem_pkg::MODE_DATA_BYTE: begin
                if (r_open && !(i_record_first && i_count_or_length == 16'd0)) begin
                    e = r_err || (i_record_first
                                  && (17'(r_wp) + 17'(i_count_or_length) > capx));
                    if (!e) begin
                        if (17'(r_wp) + 17'd1 > capx) begin
                            e = 1'b1;
                        end else begin
                            o_desc.body = {i_data_value, 152'd0};
                            o_desc.body_addr = 16'(r_wp);
                            o_desc.body_n = 5'd1;
                            n_wp = r_wp + AB'(1);
                        end
                    end
                    n_err = e;
                    if (i_record_last && !e) begin
                        n_rt = r_rt + 16'd1;
                    end
                    o_desc.ok = !e;
                end
            end
            fem_pkg::MODE_SET_END: begin
                o_desc.ok = r_open && !cl_err;
            end
            fem_pkg::MODE_FINISH: begin
                if (!base_err) begin
                    o_desc.pb_en = 1'b1;
                    o_desc.pb_addr = fem_pkg::COUNT_OFFSET;
                    o_desc.pb_val = r_ipf ? 16'(base_wp) : r_rt;
                    o_desc.mlen = 16'(base_wp);
                    o_desc.ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_dss <= '0;
            r_tss <= '0;
            r_open <= 1'b0;
            r_tfl <= '0;
            r_rt <= '0;
            r_ipf <= 1'b0;
            r_err <= 1'b0;
        end else if (i_take) begin
            r_wp <= n_wp;
            r_dss <= n_dss;
            r_tss <= n_tss;
            r_open <= n_open;
            r_tfl <= n_tfl;
            r_rt <= n_rt;
            r_ipf <= n_ipf;
            r_err <= n_err;
        end
    end

endmodule

`default_nettype wire

>>> sv/fem_queue.sv
// ----------------------------------------------------------------------------
// fem_queue
// Short queue of write plans between the decoder and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module fem_queue (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  fem_pkg::t_desc  i_desc,
    input  wire logic       i_pop,
    output logic            o_full,
    output logic            o_empty,
    output fem_pkg::t_desc  o_head
);

    fem_pkg::t_desc r_mem [fem_pkg::QUEUE_DEPTH];
    logic           r_wr, r_rd;
    logic [1:0]     r_count;

    assign o_full = r_count == 2'(fem_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == 2'd0;
    assign o_head = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/fem_back.sv
// ----------------------------------------------------------------------------
// fem_back
// Walks a write plan one result per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module fem_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_have,
    input  fem_pkg::t_desc   i_desc,
    output logic             o_pop,
    input  wire logic        i_out_stall,
    output logic             o_out_valid,
    output logic             o_write_valid,
    output logic [15:0]      o_write_address,
    output logic [7:0]       o_write_byte,
    output logic             o_op_ok,
    output logic [15:0]      o_message_length,
    output logic             o_last
);

    logic [4:0]  r_k;
    logic        r_ov;
    logic        r_wv;
    logic [15:0] r_addr;
    logic [7:0]  r_byte;
    logic        r_ok;
    logic [15:0] r_mlen;
    logic        r_last;

    logic        load;
    logic [4:0]  pa2, pb2, total;
    logic [4:0]  k2, k3, k4;
    logic        is_last;
    logic [15:0] n_addr;
    logic [7:0]  n_byte;

    assign pa2 = i_desc.pa_en ? 5'd2 : 5'd0;
    assign pb2 = i_desc.pb_en ? 5'd2 : 5'd0;
    assign total = 5'(i_desc.pad_n) + pa2 + i_desc.body_n + pb2;
    assign is_last = (total == 5'd0) || (r_k == total - 5'd1);
    assign load = i_have && (!r_ov || !i_out_stall);
    assign o_pop = load && is_last;

    always_comb begin
        k2 = r_k - 5'(i_desc.pad_n);
        k3 = k2 - pa2;
        k4 = k3 - i_desc.body_n;
        n_addr = '0;
        n_byte = '0;
        if (total == 5'd0) begin
            n_addr = '0;
        end else if (r_k < 5'(i_desc.pad_n)) begin
            n_addr = i_desc.pad_addr + 16'(r_k);
        end else if (k2 < pa2) begin
            n_addr = i_desc.pa_addr + 16'(k2[0]);
            n_byte = k2[0] ? i_desc.pa_val[7:0] : i_desc.pa_val[15:8];
        end else if (k3 < i_desc.body_n) begin
            n_addr = i_desc.body_addr + 16'(k3);
            for (int i = 0; i < fem_pkg::BODY_BYTES; i++) begin
                if (k3 == 5'(i)) begin
                    n_byte = i_desc.body[159 - 8 * i -: 8];
                end
            end
        end else begin
            n_addr = i_desc.pb_addr + 16'(k4[0]);
            n_byte = k4[0] ? i_desc.pb_val[7:0] : i_desc.pb_val[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
            r_ov <= 1'b0;
        end else if (load) begin
            r_ov <= 1'b1;
            r_k <= is_last ? 5'd0 : r_k + 5'd1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_wv <= total != 5'd0;
            r_addr <= n_addr;
            r_byte <= n_byte;
            r_ok <= is_last && i_desc.ok;
            r_mlen <= is_last ? i_desc.mlen : 16'd0;
            r_last <= is_last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_write_valid = r_wv;
    assign o_write_address = r_addr;
    assign o_write_byte = r_byte;
    assign o_op_ok = r_ok;
    assign o_message_length = r_mlen;
    assign o_last = r_last;

endmodule

`default_nettype wire

>>> sv/flow_export_message_builder.sv
// ----------------------------------------------------------------------------
// flow_export_message_builder
// NetFlow v9 / IPFIX message builder: turns command items into buffer writes.
// ----------------------------------------------------------------------------
// An accepted item's plan is written into the plan queue, then loaded into the
//   output register. One result per cycle while i_out_stall is low; an item with
//   n writes gives max(n,1) results, so data bytes stream at 1 per cycle.
// The decoder takes an item per cycle while the 2-entry plan queue has room.
// Reset (i_rst_n low, synchronous) clears all builder state, empties the
//   queue and sets the capacity register to 65535.
`default_nettype none

module flow_export_message_builder #(
    parameter int ADDRESS_BITS = fem_pkg::ADDRESS_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: buffer capacity
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    // command items
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_mode,
    input  wire logic        i_use_ipfix,
    input  wire logic [31:0] i_header_word_0,
    input  wire logic [31:0] i_header_word_1,
    input  wire logic [31:0] i_header_word_2,
    input  wire logic [31:0] i_header_word_3,
    input  wire logic [15:0] i_id_or_type,
    input  wire logic [15:0] i_count_or_length,
    input  wire logic [7:0]  i_data_value,
    input  wire logic        i_record_first,
    input  wire logic        i_record_last,
    // result items
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_write_valid,
    output logic [15:0]      o_write_address,
    output logic [7:0]       o_write_byte,
    output logic             o_op_ok,
    output logic [15:0]      o_message_length,
    output logic             o_last
);

    logic [15:0]    r_cap;
    logic           take;
    logic           q_full, q_empty, q_pop;
    fem_pkg::t_desc f_desc, q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= fem_pkg::CAPACITY_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // the front stalls only when the plan queue is full
    assign o_in_stall = q_full;
    assign take = i_in_valid && !q_full;

    // front: decode, capacity checks, state update, one plan per item
    fem_front #(.ADDRESS_BITS(ADDRESS_BITS)) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cap             (r_cap),
        .i_take            (take),
        .i_mode            (i_mode),
        .i_use_ipfix       (i_use_ipfix),
        .i_header_word_0   (i_header_word_0),
        .i_header_word_1   (i_header_word_1),
        .i_header_word_2   (i_header_word_2),
        .i_header_word_3   (i_header_word_3),
        .i_id_or_type      (i_id_or_type),
        .i_count_or_length (i_count_or_length),
        .i_data_value      (i_data_value),
        .i_record_first    (i_record_first),
        .i_record_last     (i_record_last),
        .o_desc            (f_desc)
    );

    fem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_desc  (f_desc),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // back: expands a plan into pad, patch, body and patch writes
    fem_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_have           (!q_empty),
        .i_desc           (q_head),
        .o_pop            (q_pop),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_write_valid    (o_write_valid),
        .o_write_address  (o_write_address),
        .o_write_byte     (o_write_byte),
        .o_op_ok          (o_op_ok),
        .o_message_length (o_message_length),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire
